>>> hw/rtl/pgf_pkg.sv
// ----------------------------------------------------------------------------
// pgf_pkg
// Types and constants shared by the pairwise gravity force pipeline.
// ----------------------------------------------------------------------------
package pgf_pkg;

    localparam int COORD_W    = 32;
    localparam int MASS_W     = 16;
    localparam int FORCE_W    = 48;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 16;
    localparam int SCALE_SH   = 32;
    localparam int MUL_LIMB   = 32;
    localparam int INV_PI_W   = 31;

    localparam logic [INV_PI_W-1:0] INV_PI_Q32    = 31'd1367130551;
    localparam logic [CFG_W-1:0]    GRAVITY_RESET = 32'd655360;
    localparam logic [CFG_W-1:0]    RATIO_RESET   = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY = 2'd0,
        CFG_RATIO   = 2'd1
    } cfg_index_e;

    typedef struct packed {
        logic signed [COORD_W-1:0] self_x;
        logic signed [COORD_W-1:0] self_y;
        logic        [MASS_W-1:0]  self_mass;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic        [MASS_W-1:0]  other_mass;
    } pair_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      applied;
    } result_t;

endpackage

>>> hw/rtl/pgf_dly.sv
// ----------------------------------------------------------------------------
// pgf_dly
// Enabled delay line that aligns operands between pipeline branches.
// ----------------------------------------------------------------------------
module pgf_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    if (D == 0) begin : g_pass
        assign q = d;
    end
    else begin : g_line
        logic [W-1:0] tap_reg [D];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tap_reg[0] <= d;
                for (int k = 1; k < D; k++)
                begin
                    tap_reg[k] <= tap_reg[k-1];
                end
            end
        end

        assign q = tap_reg[D-1];
    end

endmodule

>>> hw/rtl/pgf_mul.sv
// ----------------------------------------------------------------------------
// pgf_mul
// Two-stage multiplier: registered limb partial products, then their sum.
// ----------------------------------------------------------------------------
module pgf_mul
    import pgf_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int NA = (AW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB = (BW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int SW = MUL_LIMB * (NA + NB);

    logic [NA*MUL_LIMB-1:0] a_ext;
    logic [NB*MUL_LIMB-1:0] b_ext;
    logic [2*MUL_LIMB-1:0]  pp_reg [NA*NB];
    logic [SW-1:0]          sum;
    logic [AW+BW-1:0]       p_reg;

    assign a_ext = (NA*MUL_LIMB)'(a);
    assign b_ext = (NB*MUL_LIMB)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= a_ext[i*MUL_LIMB +: MUL_LIMB]
                                    * b_ext[j*MUL_LIMB +: MUL_LIMB];
                end
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum = sum + (SW'(pp_reg[i*NB+j]) << (MUL_LIMB*(i+j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/pgf_sqrt.sv
// ----------------------------------------------------------------------------
// pgf_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module pgf_sqrt #(
    parameter int IW = 32,
    parameter int OW = (IW + 1) / 2
) (
    input  logic          clk,
    input  logic          en,
    input  logic [IW-1:0] v,
    output logic [OW-1:0] root
);

    localparam int TW = 2*OW + 1;

    logic [TW-1:0] rem_reg  [1:OW];
    logic [OW-1:0] root_reg [1:OW];

    for (genvar k = 0; k < OW; k++) begin : g_step
        localparam int B = OW - 1 - k;
        logic [TW-1:0] cur_rem;
        logic [OW-1:0] cur_root;
        logic [TW-1:0] trial;

        if (k == 0) begin : g_first
            assign cur_rem  = TW'(v);
            assign cur_root = '0;
        end
        else begin : g_next
            assign cur_rem  = rem_reg[k];
            assign cur_root = root_reg[k];
        end

        assign trial = (TW'(cur_root) << (B+1)) + (TW'(1) << (2*B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur_rem >= trial)
                begin
                    rem_reg[k+1]  <= cur_rem - trial;
                    root_reg[k+1] <= cur_root | (OW'(1) << B);
                end
                else
                begin
                    rem_reg[k+1]  <= cur_rem;
                    root_reg[k+1] <= cur_root;
                end
            end
        end
    end

    assign root = root_reg[OW];

endmodule

>>> hw/rtl/pgf_div.sv
// ----------------------------------------------------------------------------
// pgf_div
// Pipelined saturating divider, one quotient bit per stage, signed result.
// ----------------------------------------------------------------------------
module pgf_div
    import pgf_pkg::*;
#(
    parameter int NW = 129,
    parameter int DW = 99
) (
    input  logic               clk,
    input  logic               en,
    input  logic [NW-1:0]      num,
    input  logic [DW-1:0]      den,
    input  logic               neg,
    input  logic               app,
    output logic [FORCE_W-1:0] quo
);

    localparam int QW = FORCE_W;
    localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;
    localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

    logic [XW-1:0] num_x;
    logic [XW-1:0] den_x;

    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] nlo_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];
    logic          neg_reg [QW+1];
    logic          app_reg [QW+1];

    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic [QW-1:0] sres;
    logic [QW-1:0] quo_next;
    logic [QW-1:0] quo_reg;

    assign num_x = XW'(num);
    assign den_x = XW'(den) << QW;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num_x >> QW);
            den_reg[0] <= den;
            nlo_reg[0] <= num[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_x >= den_x);
            neg_reg[0] <= neg;
            app_reg[0] <= app;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] trial;
        logic        take;

        assign trial = {rem_reg[k], nlo_reg[k][QW-1-k]};
        assign take  = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? DW'(trial - {1'b0, den_reg[k]}) : DW'(trial);
                q_reg[k+1]   <= {q_reg[k][QW-2:0], take};
                den_reg[k+1] <= den_reg[k];
                nlo_reg[k+1] <= nlo_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                app_reg[k+1] <= app_reg[k];
            end
        end
    end

    always_comb
    begin
        lim      = neg_reg[QW] ? LIM_NEG : LIM_POS;
        mag      = (ovf_reg[QW] || (q_reg[QW] > lim)) ? lim : q_reg[QW];
        sres     = neg_reg[QW] ? -mag : mag;
        quo_next = app_reg[QW] ? sres : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> hw/rtl/pairwise_gravity_force_core.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force_core
// Path from accepted pair to result: radius/distance square roots, distance
//   cube, then a 48-stage one-bit-per-stage divider.
// Throughput: one pair per cycle; a stalled result freezes the whole pipeline.
// Reset: clears all valid bits and loads G = 10.0 and diameter ratio = 1.0.
// ----------------------------------------------------------------------------
module pairwise_gravity_force_core
    import pgf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pair_valid,
    output logic                 pair_stall,
    input  pair_t                pair,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DIST_W = COORD_W + 1;
    localparam int D2_W   = 2*DIST_W;
    localparam int MP_W   = MASS_W + INV_PI_W;
    localparam int ROOT_W = (MP_W + 1) / 2;
    localparam int RAD_W  = ROOT_W + CFG_W - FRAC_W;
    localparam int RSUM_W = RAD_W + 1;
    localparam int CMP_W  = (DIST_W > RSUM_W) ? DIST_W : RSUM_W;
    localparam int GM_W   = CFG_W + MASS_W;
    localparam int GMM_W  = GM_W + MASS_W;
    localparam int P_W    = GMM_W + DIST_W;
    localparam int N_W    = P_W + SCALE_SH;
    localparam int DEN_W  = 3*DIST_W;
    localparam int T_D    = 5 + DIST_W;
    localparam int T_R    = 6 + ROOT_W;
    localparam int T_C    = (T_D > T_R) ? T_D : T_R;
    localparam int T_V    = T_C + 4;
    localparam int LAT    = T_V + FORCE_W + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic [CFG_W-1:0] g_reg;
    logic [CFG_W-1:0] ratio_reg;

    logic [DIST_W-1:0] dx_reg, dy_reg, ax_reg, ay_reg;
    logic [MASS_W-1:0] ms_reg, mo_reg;
    logic              sx_reg, sy_reg;

    logic [D2_W-1:0]         ax2, ay2, d2_reg;
    logic [DIST_W-1:0]       dist_root, dist_c, dist_c2;
    logic [MP_W-1:0]         mps, mpo;
    logic [ROOT_W-1:0]       root_s, root_o;
    logic [ROOT_W+CFG_W-1:0] rps, rpo;
    logic [RSUM_W-1:0]       rsum_reg, rsum_c;
    logic                    applied_reg, app_v, app_out;
    logic [2*DIST_W-1:0]     dsq;
    logic [DEN_W-1:0]        dcube;
    logic [GM_W-1:0]         gm;
    logic [MASS_W-1:0]       mo_d;
    logic [GMM_W-1:0]        gmm;
    logic [DIST_W-1:0]       ax_d, ay_d;
    logic [P_W-1:0]          px, py, px_v, py_v;
    logic [1:0]              sgn_v;
    logic [FORCE_W-1:0]      fx, fy;

    assign en         = !(vld_reg[LAT-1] && result_stall);
    assign pair_stall = !en;
    assign cfg_ready  = 1'b1;
    assign vld_next   = {vld_reg[LAT-2:0], pair_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg     <= GRAVITY_RESET;
            ratio_reg <= RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRAVITY: g_reg     <= cfg_data;
                CFG_RATIO:   ratio_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= {pair.other_x[COORD_W-1], pair.other_x}
                    - {pair.self_x[COORD_W-1], pair.self_x};
            dy_reg <= {pair.other_y[COORD_W-1], pair.other_y}
                    - {pair.self_y[COORD_W-1], pair.self_y};
            ms_reg <= pair.self_mass;
            mo_reg <= pair.other_mass;
            ax_reg <= dx_reg[DIST_W-1] ? -dx_reg : dx_reg;
            ay_reg <= dy_reg[DIST_W-1] ? -dy_reg : dy_reg;
            sx_reg <= dx_reg[DIST_W-1];
            sy_reg <= dy_reg[DIST_W-1];
            d2_reg <= ax2 + ay2;
            rsum_reg <= {1'b0, rps[ROOT_W+CFG_W-1:FRAC_W]}
                      + {1'b0, rpo[ROOT_W+CFG_W-1:FRAC_W]};
            applied_reg <= (CMP_W'(dist_c) > CMP_W'(rsum_c));
        end
    end

    // distance
    pgf_mul #(.AW(DIST_W), .BW(DIST_W)) u_mul_ax (
        .clk(clk), .en(en), .a(ax_reg), .b(ax_reg), .p(ax2));
    pgf_mul #(.AW(DIST_W), .BW(DIST_W)) u_mul_ay (
        .clk(clk), .en(en), .a(ay_reg), .b(ay_reg), .p(ay2));
    pgf_sqrt #(.IW(D2_W), .OW(DIST_W)) u_sqrt_d (
        .clk(clk), .en(en), .v(d2_reg), .root(dist_root));

    // radii
    pgf_mul #(.AW(MASS_W), .BW(INV_PI_W)) u_mul_ms (
        .clk(clk), .en(en), .a(ms_reg), .b(INV_PI_Q32), .p(mps));
    pgf_mul #(.AW(MASS_W), .BW(INV_PI_W)) u_mul_mo (
        .clk(clk), .en(en), .a(mo_reg), .b(INV_PI_Q32), .p(mpo));
    pgf_sqrt #(.IW(MP_W), .OW(ROOT_W)) u_sqrt_ms (
        .clk(clk), .en(en), .v(mps), .root(root_s));
    pgf_sqrt #(.IW(MP_W), .OW(ROOT_W)) u_sqrt_mo (
        .clk(clk), .en(en), .v(mpo), .root(root_o));
    pgf_mul #(.AW(ROOT_W), .BW(CFG_W)) u_mul_rs (
        .clk(clk), .en(en), .a(root_s), .b(ratio_reg), .p(rps));
    pgf_mul #(.AW(ROOT_W), .BW(CFG_W)) u_mul_ro (
        .clk(clk), .en(en), .a(root_o), .b(ratio_reg), .p(rpo));

    // align distance and radius sum
    pgf_dly #(.W(DIST_W), .D(T_C - T_D)) u_dly_dist (
        .clk(clk), .en(en), .d(dist_root), .q(dist_c));
    pgf_dly #(.W(RSUM_W), .D(T_C - T_R)) u_dly_rsum (
        .clk(clk), .en(en), .d(rsum_reg), .q(rsum_c));

    // denominator
    pgf_mul #(.AW(DIST_W), .BW(DIST_W)) u_mul_dsq (
        .clk(clk), .en(en), .a(dist_c), .b(dist_c), .p(dsq));
    pgf_dly #(.W(DIST_W), .D(2)) u_dly_dist2 (
        .clk(clk), .en(en), .d(dist_c), .q(dist_c2));
    pgf_mul #(.AW(2*DIST_W), .BW(DIST_W)) u_mul_dcube (
        .clk(clk), .en(en), .a(dsq), .b(dist_c2), .p(dcube));

    // numerator
    pgf_mul #(.AW(CFG_W), .BW(MASS_W)) u_mul_gm (
        .clk(clk), .en(en), .a(g_reg), .b(ms_reg), .p(gm));
    pgf_dly #(.W(MASS_W), .D(2)) u_dly_mo (
        .clk(clk), .en(en), .d(mo_reg), .q(mo_d));
    pgf_mul #(.AW(GM_W), .BW(MASS_W)) u_mul_gmm (
        .clk(clk), .en(en), .a(gm), .b(mo_d), .p(gmm));
    pgf_dly #(.W(DIST_W), .D(3)) u_dly_ax (
        .clk(clk), .en(en), .d(ax_reg), .q(ax_d));
    pgf_dly #(.W(DIST_W), .D(3)) u_dly_ay (
        .clk(clk), .en(en), .d(ay_reg), .q(ay_d));
    pgf_mul #(.AW(GMM_W), .BW(DIST_W)) u_mul_px (
        .clk(clk), .en(en), .a(gmm), .b(ax_d), .p(px));
    pgf_mul #(.AW(GMM_W), .BW(DIST_W)) u_mul_py (
        .clk(clk), .en(en), .a(gmm), .b(ay_d), .p(py));
    pgf_dly #(.W(P_W), .D(T_V - 7)) u_dly_px (
        .clk(clk), .en(en), .d(px), .q(px_v));
    pgf_dly #(.W(P_W), .D(T_V - 7)) u_dly_py (
        .clk(clk), .en(en), .d(py), .q(py_v));

    pgf_dly #(.W(1), .D(T_V - T_C - 1)) u_dly_app (
        .clk(clk), .en(en), .d(applied_reg), .q(app_v));
    pgf_dly #(.W(2), .D(T_V - 2)) u_dly_sgn (
        .clk(clk), .en(en), .d({sx_reg, sy_reg}), .q(sgn_v));

    // divide and saturate
    pgf_div #(.NW(N_W), .DW(DEN_W)) u_div_x (
        .clk(clk), .en(en), .num({px_v, {SCALE_SH{1'b0}}}), .den(dcube),
        .neg(sgn_v[1]), .app(app_v), .quo(fx));
    pgf_div #(.NW(N_W), .DW(DEN_W)) u_div_y (
        .clk(clk), .en(en), .num({py_v, {SCALE_SH{1'b0}}}), .den(dcube),
        .neg(sgn_v[0]), .app(app_v), .quo(fy));
    pgf_dly #(.W(1), .D(FORCE_W + 2)) u_dly_app_out (
        .clk(clk), .en(en), .d(app_v), .q(app_out));

    assign result_valid   = vld_reg[LAT-1];
    assign result.force_x = fx;
    assign result.force_y = fy;
    assign result.applied = app_out;

endmodule

>>> hw/rtl/pgf_checker.sv
// ----------------------------------------------------------------------------
// pgf_checker
// Port-level checks on the pairwise gravity force core, bound to the top.
// ----------------------------------------------------------------------------
module pgf_checker
    import pgf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pair_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> result_valid && result_stall)
        else $error("input stalled without a stalled result item");

    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.applied |-> result.force_x == '0 && result.force_y == '0)
        else $error("force present on an item that was not applied");

endmodule

bind pairwise_gravity_force_core pgf_checker u_pgf_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Pairwise gravity force core testbench
// Sends body pairs through the core under several register settings and
// handshake patterns. Every result is checked in order against an exact
// wide-integer model of the force, the contact test and saturation.
// ----------------------------------------------------------------------------
module testbench;
    import pgf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int DRAIN_CYCLES = 120;

    class force_scoreboard;
        logic [CFG_W-1:0] gravity;
        logic [CFG_W-1:0] ratio;
        result_t          expected_forces[$];
        int               errors;
        int               checked;
        int               contacts;

        function new();
            gravity = GRAVITY_RESET;
            ratio   = RATIO_RESET;
            errors  = 0;
            checked = 0;
            contacts = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_GRAVITY)
                gravity = value;
            else if (idx == CFG_RATIO)
                ratio = value;
        endfunction

        function logic [63:0] int_sqrt(logic [127:0] v);
            logic [63:0]  root;
            logic [63:0]  trial;
            logic [127:0] sq;
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                sq = 128'(trial) * 128'(trial);
                if (sq <= v)
                    root = trial;
            end
            return root;
        endfunction

        function logic [63:0] body_radius(logic [MASS_W-1:0] m);
            logic [63:0] s;
            s = int_sqrt(128'(64'(m) * 64'(INV_PI_Q32)));
            return (s * 64'(ratio)) >> FRAC_W;
        endfunction

        function logic [FORCE_W-1:0] axis_force(longint delta, logic [63:0] d_len,
                                                logic [MASS_W-1:0] ms,
                                                logic [MASS_W-1:0] mo);
            logic         neg;
            logic [63:0]  mag;
            logic [255:0] num;
            logic [255:0] den;
            logic [255:0] quot;
            logic [255:0] lim;
            neg = delta < 0;
            mag = neg ? 64'(-delta) : 64'(delta);
            num = 256'(gravity) * 256'(ms) * 256'(mo) * 256'(mag);
            num = num << SCALE_SH;
            den = 256'(d_len) * 256'(d_len) * 256'(d_len);
            quot = num / den;
            lim = neg ? (256'd1 << (FORCE_W - 1)) : ((256'd1 << (FORCE_W - 1)) - 1);
            if (quot > lim)
                quot = lim;
            return neg ? -quot[FORCE_W-1:0] : quot[FORCE_W-1:0];
        endfunction

        function void note_pair(pair_t p);
            result_t     r;
            longint      dx;
            longint      dy;
            logic [63:0] ax;
            logic [63:0] ay;
            logic [63:0] d_len;
            logic [63:0] rsum;
            dx = longint'(p.other_x) - longint'(p.self_x);
            dy = longint'(p.other_y) - longint'(p.self_y);
            ax = dx < 0 ? 64'(-dx) : 64'(dx);
            ay = dy < 0 ? 64'(-dy) : 64'(dy);
            d_len = int_sqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
            rsum = body_radius(p.self_mass) + body_radius(p.other_mass);
            if (d_len > rsum)
            begin
                r.force_x = axis_force(dx, d_len, p.self_mass, p.other_mass);
                r.force_y = axis_force(dy, d_len, p.self_mass, p.other_mass);
                r.applied = 1'b1;
            end
            else
            begin
                r = '0;
                contacts++;
            end
            expected_forces.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_forces.size() == 0)
            begin
                $error("unexpected result: force_x=%0d force_y=%0d applied=%0b",
                       got.force_x, got.force_y, got.applied);
                errors++;
                return;
            end
            want = expected_forces.pop_front();
            checked++;
            if (got.force_x !== want.force_x)
            begin
                $error("force_x: expected %0d, actual %0d", want.force_x, got.force_x);
                errors++;
            end
            if (got.force_y !== want.force_y)
            begin
                $error("force_y: expected %0d, actual %0d", want.force_y, got.force_y);
                errors++;
            end
            if (got.applied !== want.applied)
            begin
                $error("applied: expected %0b, actual %0b", want.applied, got.applied);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 pair_valid;
    logic                 pair_stall;
    pair_t                pair;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    force_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int pairs_sent;

    pairwise_gravity_force_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stall, long hold-off on request
    initial
    begin
        int held;
        held = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
            @(negedge clk);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                held--;
                result_stall = 1'b1;
            end
            else
                result_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            pair_valid = 1'b0;
        end
        @(negedge clk);
        pair_valid = 1'b1;
        pair = p;
        do
            @(posedge clk);
        while (pair_stall);
        sb.note_pair(p);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pair_valid = 1'b0;
        while (sb.expected_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic pair_t make_pair(logic signed [31:0] sx, logic signed [31:0] sy,
                                        logic [15:0] sm, logic signed [31:0] ox,
                                        logic signed [31:0] oy, logic [15:0] om);
        pair_t p;
        p.self_x = sx;
        p.self_y = sy;
        p.self_mass = sm;
        p.other_x = ox;
        p.other_y = oy;
        p.other_mass = om;
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    span;
        p.self_x = $urandom;
        p.self_y = $urandom;
        case ($urandom_range(3))
            0: p.self_mass = 16'($urandom);
            1: p.self_mass = 16'($urandom_range(0, 15));
            default: p.self_mass = 16'($urandom_range(0, 400));
        endcase
        case ($urandom_range(3))
            0: p.other_mass = 16'($urandom);
            1: p.other_mass = 16'($urandom_range(0, 15));
            default: p.other_mass = 16'($urandom_range(0, 400));
        endcase
        if ($urandom_range(3) == 0)
        begin
            p.other_x = $urandom;
            p.other_y = $urandom;
        end
        else
        begin
            span = 1 << $urandom_range(8, 26);
            p.other_x = p.self_x + $signed($urandom_range(0, 2 * span)) - span;
            p.other_y = p.self_y + $signed($urandom_range(0, 2 * span)) - span;
        end
        return p;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRAVITY;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        pairs_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pair(make_pair(0, 0, 100, 0, 0, 100));
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                            32'h8000_0000, 32'h8000_0000, 16'hFFFF));
        send_pair(make_pair(0, 0, 0, 32'h0001_0000, 0, 5));
        send_pair(make_pair(0, 0, 1, 0, 32'h0000_0001, 1));
        send_pair(make_pair(0, 0, 16'hFFFF, 1, 1, 16'hFFFF));
        send_pair(make_pair(0, 0, 1, 32'h0000_0100, 32'hFFFF_FF00, 1));
        send_pair(make_pair(0, 0, 1, 32'h0000_2000, 0, 1));
        send_pair(make_pair(0, 0, 1, 32'h0002_0000, 32'h0001_0000, 1));
        send_pair(make_pair(32'h0010_0000, 32'hFFF0_0000, 3,
                            32'hFFF0_0000, 32'h0010_0000, 7));
        send_pair(make_pair(32'h1234_5678, 32'h0BCD_EF01, 16'h00FF,
                            32'h1234_5678, 32'h0BCD_EF01, 16'h00FF));
        send_pair(make_pair(0, 0, 16'hFFFF, 32'h7FFF_FFFF, 0, 16'hFFFF));
        send_pair(make_pair(0, 0, 16'h8000, 0, 32'h8000_0000, 16'h0001));
        wait_drained();

        write_reg(CFG_GRAVITY, 32'hFFFF_FFFF);
        write_reg(CFG_RATIO, 32'd0);
        write_reg(CFG_SPARE_LO, 32'h0000_0001);
        send_pair(make_pair(0, 0, 16'hFFFF, 1, 0, 16'hFFFF));
        send_pair(make_pair(0, 0, 16'hFFFF, 0, 32'hFFFF_FFFF, 16'hFFFF));
        send_pair(make_pair(0, 0, 0, 0, 0, 16'hFFFF));
        run_random(150);
        wait_drained();

        send_idle_pct = 54;
        write_reg(CFG_GRAVITY, 32'd0);
        write_reg(CFG_RATIO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
        run_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 54;
        write_reg(CFG_GRAVITY, GRAVITY_RESET);
        write_reg(CFG_RATIO, RATIO_RESET);
        run_random(150);
        hold_request = 300;
        run_random(150);
        wait_drained();

        send_idle_pct = 35;
        recv_stall_pct = 35;
        write_reg(CFG_GRAVITY, $urandom);
        write_reg(CFG_RATIO, $urandom_range(0, 32'h0004_0000));
        run_random(150);
        wait_drained();
        run_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_GRAVITY, 32'h0000_0001);
        write_reg(CFG_RATIO, 32'h0000_8000);
        run_random(100);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        run_random(100);
        wait_drained();

        $display("covered %0d pairs, %0d results checked, %0d in contact, 6 register settings",
                 pairs_sent, sb.checked, sb.contacts);
        if (sb.errors == 0 && sb.expected_forces.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pgf_pkg.sv
hw/rtl/pgf_dly.sv
hw/rtl/pgf_mul.sv
hw/rtl/pgf_sqrt.sv
hw/rtl/pgf_div.sv
hw/rtl/pairwise_gravity_force_core.sv
hw/rtl/pgf_checker.sv
bench/testbench.sv
